@@ rtl/rcnt_pkg.sv @@
// package for the four channel root counter timer unit
// types, codes and constants shared by front and back end; no dependencies
package rcnt_pkg;

  localparam int unsigned CYCLE_BIAS_DEF = 2;
  localparam logic [19:0] VSYNC_RESET    = 20'd564480;
  localparam logic [9:0]  MODE3_RESET    = 10'h058;
  localparam logic [15:0] TOP_FULL       = 16'hffff;
  localparam logic [31:0] NEVER_DL       = 32'hffffffff;
  localparam logic [8:0]  LINE_DIV       = 9'd386;
  localparam logic [8:0]  FRAME_DIV      = 9'd262;
  localparam logic [9:0]  RATE_SEL_MASK  = 10'h300;
  localparam logic [9:0]  RATE_SEL_A     = 10'h100;
  localparam logic [9:0]  RATE_SEL_B     = 10'h200;
  localparam logic [9:0]  MODE_TGT       = 10'h010;
  localparam logic [9:0]  MODE_IRQ_MASK  = 10'h030;
  localparam logic [9:0]  MODE_REPEAT    = 10'h040;
  localparam logic [19:0] RATE_EIGHT     = 20'd8;

  // line times frame divisor, and how many multiples of it fit in 20 bits
  localparam logic [16:0] LINE_FRAME_DIV = 17'd101132;
  localparam int unsigned RATE0_STEPS    = 10;
  // ceil(2^27 / 131): exact reciprocal for a 19-bit dividend
  localparam logic [19:0] FRAME_RECIP    = 20'd1024563;

  typedef enum logic [2:0] {
    FN_TICK   = 3'd0,
    FN_WCOUNT = 3'd1,
    FN_WMODE  = 3'd2,
    FN_WTGT   = 3'd3,
    FN_READ   = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  index;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [3:0]  irq_raise;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic        tick;
    logic        wcount;
    logic        wmode;
    logic        wtgt;
    logic        rd;
    logic [1:0]  idx;
    logic [15:0] value;
  } cmd_t;

endpackage

@@ rtl/rcnt_front.sv @@
// front end: accepts input transactions and decodes them into commands
// depends on rcnt_pkg
module rcnt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rcnt_pkg::in_item_t in_data,
  output logic               cmd_valid,
  input  logic               cmd_stall,
  output rcnt_pkg::cmd_t     cmd
);
  import rcnt_pkg::*;

  logic   valid_r, valid_nxt;
  cmd_t   cmd_r, cmd_nxt;
  logic   take;

  assign in_stall  = valid_r && cmd_stall;
  assign take      = in_valid && !in_stall;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  // decode func code
  always_comb begin
    cmd_nxt       = cmd_r;
    valid_nxt     = valid_r && cmd_stall;
    if (take) begin
      valid_nxt     = 1'b1;
      cmd_nxt       = '0;
      cmd_nxt.idx   = in_data.index;
      cmd_nxt.value = in_data.value;
      unique case (in_data.func)
        FN_TICK:   cmd_nxt.tick   = 1'b1;
        FN_WCOUNT: cmd_nxt.wcount = 1'b1;
        FN_WMODE:  cmd_nxt.wmode  = 1'b1;
        FN_WTGT:   cmd_nxt.wtgt   = 1'b1;
        FN_READ:   cmd_nxt.rd     = 1'b1;
        default:   cmd_nxt.rd     = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end
endmodule

@@ rtl/rcnt_back.sv @@
// back end: counter state, deadlines and result register
// depends on rcnt_pkg
module rcnt_back #(
  parameter int unsigned CYCLE_BIAS = rcnt_pkg::CYCLE_BIAS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [19:0]         cfg_data,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  rcnt_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output rcnt_pkg::out_item_t out_data
);
  import rcnt_pkg::*;

  logic [15:0] count_r [4];
  logic [9:0]  mode_r  [4];
  logic [15:0] tgt_r   [4];
  logic [19:0] rate_r  [4];
  logic [31:0] elap_r  [4];
  logic [19:0] pre_r   [4];
  logic [31:0] scal_r  [4];
  logic [31:0] dl_r    [4];
  logic        never_r [4];
  logic [19:0] vsync_r;
  logic [19:0] rate0_r, rate1_r;
  logic [19:0] rate0_nxt, rate1_nxt;
  logic [38:0] frame_prod;
  logic        ovalid_r;
  out_item_t   odata_r;

  logic go;
  assign cmd_stall = ovalid_r && out_stall;
  assign go        = cmd_valid && !cmd_stall;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  // deadline for a restart with given fields, kept as span times rate;
  // the bias division is folded into the reach test
  function automatic logic [32:0] calc_dl(input logic [1:0] n, input logic [9:0] m,
                                          input logic [15:0] t, input logic [15:0] c,
                                          input logic [19:0] r);
    logic [31:0] span;
    logic [31:0] prod;
    calc_dl = '0;
    span    = ((m & MODE_TGT) != '0) ? ({16'd0, t} - {16'd0, c}) : {16'd0, TOP_FULL - c};
    prod    = span * {12'd0, r};
    if ((m & MODE_IRQ_MASK) != '0 && !(n == 2'd2 && m[0])) begin
      calc_dl = {1'b0, prod};
    end else begin
      calc_dl = {1'b1, NEVER_DL};
    end
  endfunction

  // elapsed >= floor(prod / bias) is the same as (elapsed + 1) * bias > prod
  function automatic logic hit(input logic [31:0] e, input logic [31:0] p);
    logic [36:0] lhs;
    lhs = ({5'd0, e} + 37'd1) * 37'(CYCLE_BIAS);
    hit = lhs > {5'd0, p};
  endfunction

  // derived rates: compare ladder for the line-frame rate, reciprocal for the frame rate
  always_comb begin
    rate0_nxt = '0;
    for (int k = 1; k <= RATE0_STEPS; k++) begin
      if ({4'd0, vsync_r} >= 24'(k) * {7'd0, LINE_FRAME_DIV}) rate0_nxt = 20'(k);
    end
    frame_prod = {20'd0, vsync_r[19:1]} * {19'd0, FRAME_RECIP};
    rate1_nxt  = {8'd0, frame_prod[38:27]};
  end

  always_ff @(posedge clk) begin
    rate0_r <= rate0_nxt;
    rate1_r <= rate1_nxt;
  end

  // state update per command
  always_ff @(posedge clk) begin
    logic [32:0] d;
    logic [19:0] r, nr;
    logic [15:0] nc;
    logic [9:0]  nm;
    logic [15:0] nt;
    logic [31:0] ne;
    logic [3:0]  irq;
    logic [15:0] rdv;
    if (!rst_n) begin
      vsync_r  <= VSYNC_RESET;
      ovalid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        count_r[i] <= '0; mode_r[i] <= '0; tgt_r[i] <= '0; rate_r[i] <= 20'd1;
        elap_r[i] <= '0; pre_r[i] <= '0; scal_r[i] <= '0;
        dl_r[i] <= NEVER_DL; never_r[i] <= 1'b1;
      end
      mode_r[3]  <= MODE3_RESET;
      tgt_r[3]   <= 16'd1;
      rate_r[3]  <= VSYNC_RESET;
      dl_r[3]    <= {12'd0, VSYNC_RESET};
      never_r[3] <= 1'b0;
    end else begin
      if (cfg_we) begin
        vsync_r   <= cfg_data;
        rate_r[3] <= cfg_data;
      end
      if (go) begin
        irq = '0;
        rdv = '0;
        if (cmd.tick) begin
          for (int i = 0; i < 4; i++) begin
            r  = (rate_r[i] == '0) ? 20'd1 : rate_r[i];
            ne = elap_r[i] + 32'd1;
            if (!never_r[i] && hit(ne, dl_r[i])) begin
              elap_r[i] <= '0; pre_r[i] <= '0; scal_r[i] <= '0;
              nc = (i == 3) ? count_r[i] : 16'd0;
              count_r[i] <= nc;
              d = calc_dl(2'(i), mode_r[i], tgt_r[i], nc, rate_r[i]);
              if (i != 3 && (mode_r[i] & MODE_REPEAT) == '0) d = {1'b1, NEVER_DL};
              dl_r[i] <= d[31:0]; never_r[i] <= d[32];
              irq[(i + 1) % 4] = 1'b1;
            end else begin
              elap_r[i] <= ne;
              if (pre_r[i] + 20'd1 >= r) begin
                pre_r[i] <= '0; scal_r[i] <= scal_r[i] + 32'd1;
              end else begin
                pre_r[i] <= pre_r[i] + 20'd1;
              end
            end
          end
        end
        if (cmd.wcount || cmd.wmode || cmd.wtgt) begin
          nc = cmd.wcount ? cmd.value : (cmd.wmode ? 16'd0 : count_r[cmd.idx]);
          nm = cmd.wmode ? cmd.value[9:0] : mode_r[cmd.idx];
          nt = cmd.wtgt ? cmd.value : tgt_r[cmd.idx];
          nr = rate_r[cmd.idx];
          if (cmd.wmode) begin
            unique case (cmd.idx)
              2'd0: nr = ((nm & RATE_SEL_MASK) == RATE_SEL_A) ? rate0_r : 20'd1;
              2'd1: nr = ((nm & RATE_SEL_MASK) == RATE_SEL_A) ? rate1_r : 20'd1;
              2'd2: nr = ((nm & RATE_SEL_MASK) == RATE_SEL_B) ? RATE_EIGHT : 20'd1;
              default: nr = rate_r[cmd.idx];
            endcase
          end
          count_r[cmd.idx] <= nc; mode_r[cmd.idx] <= nm; tgt_r[cmd.idx] <= nt;
          rate_r[cmd.idx]  <= nr;
          elap_r[cmd.idx] <= '0; pre_r[cmd.idx] <= '0; scal_r[cmd.idx] <= '0;
          d = calc_dl(cmd.idx, nm, nt, nc, nr);
          dl_r[cmd.idx] <= d[31:0]; never_r[cmd.idx] <= d[32];
        end
        if (cmd.rd) begin
          rdv = count_r[cmd.idx] + 16'(CYCLE_BIAS * scal_r[cmd.idx]);
        end
        ovalid_r          <= 1'b1;
        odata_r.read_data <= rdv;
        odata_r.irq_raise <= irq;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end
endmodule

@@ rtl/four_channel_root_counter_timer_unit.sv @@
// top level of the four channel root counter timer unit
// depends on rcnt_pkg, rcnt_front, rcnt_back
//
// channel   direction  handshake
// in_       input      in_valid / in_stall, in_data
// out_      output     out_valid / out_stall, out_data
// cfg_      input      cfg_we, cfg_data
//
// one transaction per cycle unless stalled; result via cmd_r then odata_r
// the front command register parts decode from the counter state update
// reset is synchronous, active low; no clearing pass
// a stalled output holds back the command register, then the input
module four_channel_root_counter_timer_unit #(
  parameter int unsigned CYCLE_BIAS = rcnt_pkg::CYCLE_BIAS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rcnt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rcnt_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [19:0]         cfg_data
);
  import rcnt_pkg::*;

  logic cmd_valid, cmd_stall;
  cmd_t cmd;

  rcnt_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cmd_valid, .cmd_stall, .cmd
  );

  rcnt_back #(.CYCLE_BIAS(CYCLE_BIAS)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_data, .cmd_valid, .cmd_stall, .cmd,
    .out_valid, .out_stall, .out_data
  );
endmodule
